### rtl/bmx_pkg.sv
// shared types and constants for the binary trie max-xor engine
`timescale 1ns / 1ps
`default_nettype none
package bmx_pkg;

   localparam int VALUE_BITS      = 32;
   localparam int KEY_BITS_DEF    = 32;
   localparam int NODE_COUNT_DEF  = 4096;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_ALLOC,
      ST_FINISH
   } state_type;

   // control word for the bit-serial key and result shifters
   typedef struct packed {
      logic load;
      logic shift;
      logic best_bit;
   } ser_ctrl_type;

endpackage
`default_nettype wire

### rtl/bmx_node_mem.sv
// trie node memory: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none
module bmx_node_mem
   import bmx_pkg::*;
#(
   parameter int NODE_COUNT = NODE_COUNT_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [$clog2(NODE_COUNT)-1:0]          wr_addr,
   input  wire logic [2*$clog2(NODE_COUNT)-1:0]        wr_data,
   input  wire logic [$clog2(NODE_COUNT)-1:0]          rd_addr,
   output logic      [2*$clog2(NODE_COUNT)-1:0]        rd_data
);

   localparam int NODE_BITS = $clog2(NODE_COUNT);

   logic [2*NODE_BITS-1:0] mem [NODE_COUNT];
   logic [2*NODE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### rtl/bmx_bit_serial.sv
// bit-serial key shifter and max-xor result accumulator
`timescale 1ns / 1ps
`default_nettype none
module bmx_bit_serial
   import bmx_pkg::*;
#(
   parameter int KEY_BITS = KEY_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire ser_ctrl_type          ctrl,
   input  wire logic [VALUE_BITS-1:0] value,
   output logic                       key_msb,
   output logic      [VALUE_BITS-1:0] best_value
);

   logic [KEY_BITS-1:0] key_ff;
   logic [KEY_BITS-1:0] key_in;
   logic [KEY_BITS-1:0] best_ff;
   logic [KEY_BITS-1:0] best_in;

   always_comb begin
      key_in  = key_ff;
      best_in = best_ff;
      if (ctrl.load) begin
         key_in  = KEY_BITS'(value);
         best_in = '0;
      end else if (ctrl.shift) begin
         key_in  = key_ff << 1;
         best_in = (best_ff << 1) | KEY_BITS'(ctrl.best_bit);
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      best_ff <= best_in;
   end

   assign key_msb    = key_ff[KEY_BITS-1];
   assign best_value = VALUE_BITS'(best_ff);

endmodule
`default_nettype wire

### rtl/binary_trie_max_xor.sv
// top level: trie walk and node allocation sequencer
`timescale 1ns / 1ps
`default_nettype none
// Binary trie max-xor engine. A word is taken when start is high and busy is low;
// op 0 inserts value as a key, op 1 returns the largest xor of value with any stored
// key. One result word per item appears on the rsp_ ports for one cycle with
// rsp_strobe; it cannot be held off. The trie sits in one node memory with a
// registered read port and is walked one key bit per cycle from the top bit. A query
// on an empty trie skips the walk and goes straight to the result. An insert walks
// each existing level, links the first new node under the last existing one, and
// makes one memory write per newly allocated node. A duplicate key walks the full
// key, and a rejected insert returns as soon as the walk finds the pool too small.
// busy stays high until the result cycle. The store is empty right after reset;
// no clearing pass is needed since nodes are written as they are allocated.
module binary_trie_max_xor
   import bmx_pkg::*;
#(
   parameter int KEY_BITS   = KEY_BITS_DEF,
   parameter int NODE_COUNT = NODE_COUNT_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic                  req_op,
   input  wire logic [VALUE_BITS-1:0] req_value,
   output logic                       rsp_strobe,
   output logic      [VALUE_BITS-1:0] rsp_max_xor,
   output logic                       rsp_found,
   output logic                       rsp_pool_full
);

   localparam int NODE_BITS = $clog2(NODE_COUNT);
   localparam int CNT_BITS  = $clog2(NODE_COUNT + 1);
   localparam int LVL_BITS  = $clog2(KEY_BITS + 1);
   localparam int SUM_BITS  = ((CNT_BITS > LVL_BITS) ? CNT_BITS : LVL_BITS) + 1;

   state_type              state_ff, state_in;
   logic                   op_ff, op_in;
   logic [LVL_BITS-1:0]    level_ff, level_in;
   logic [NODE_BITS-1:0]   node_ff, node_in;
   logic [CNT_BITS-1:0]    nodes_used_ff, nodes_used_in;
   logic                   trie_empty_ff, trie_empty_in;
   logic                   dead_ff, dead_in;
   logic                   res_found_ff, res_found_in;
   logic                   res_full_ff, res_full_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic [VALUE_BITS-1:0]  rsp_max_xor_ff, rsp_max_xor_in;
   logic                   rsp_found_ff, rsp_found_in;
   logic                   rsp_pool_full_ff, rsp_pool_full_in;

   logic                   wr_en;
   logic [NODE_BITS-1:0]   wr_addr;
   logic [2*NODE_BITS-1:0] wr_data;
   logic [NODE_BITS-1:0]   rd_addr;
   logic [2*NODE_BITS-1:0] rd_data;

   ser_ctrl_type           ser_ctrl;
   logic                   key_msb;
   logic [VALUE_BITS-1:0]  best_value;

   logic [2*NODE_BITS-1:0] entry;
   logic [NODE_BITS-1:0]   child0, child1, child_same, child_opp;
   logic [NODE_BITS-1:0]   new_node, link_node;
   logic [SUM_BITS-1:0]    need_total;
   logic                   pool_short;

   bmx_node_mem #(
      .NODE_COUNT (NODE_COUNT)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bmx_bit_serial #(
      .KEY_BITS (KEY_BITS)
   ) u_serial (
      .clock      (clock),
      .ctrl       (ser_ctrl),
      .value      (req_value),
      .key_msb    (key_msb),
      .best_value (best_value)
   );

   // root entry is never written before the first insert
   assign entry      = (trie_empty_ff && node_ff == '0) ? '0 : rd_data;
   assign child0     = entry[NODE_BITS-1:0];
   assign child1     = entry[2*NODE_BITS-1:NODE_BITS];
   assign child_same = key_msb ? child1 : child0;
   assign child_opp  = key_msb ? child0 : child1;
   assign new_node   = nodes_used_ff[NODE_BITS-1:0];
   assign link_node  = NODE_BITS'(nodes_used_ff + CNT_BITS'(1));
   assign need_total = SUM_BITS'(nodes_used_ff) + SUM_BITS'(level_ff) + SUM_BITS'(1);
   assign pool_short = need_total > SUM_BITS'(NODE_COUNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         nodes_used_ff <= CNT_BITS'(1);
         trie_empty_ff <= 1'b1;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         nodes_used_ff <= nodes_used_in;
         trie_empty_ff <= trie_empty_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff            <= op_in;
      level_ff         <= level_in;
      node_ff          <= node_in;
      dead_ff          <= dead_in;
      res_found_ff     <= res_found_in;
      res_full_ff      <= res_full_in;
      rsp_max_xor_ff   <= rsp_max_xor_in;
      rsp_found_ff     <= rsp_found_in;
      rsp_pool_full_ff <= rsp_pool_full_in;
   end

   always_comb begin
      state_in         = state_ff;
      op_in            = op_ff;
      level_in         = level_ff;
      node_in          = node_ff;
      nodes_used_in    = nodes_used_ff;
      trie_empty_in    = trie_empty_ff;
      dead_in          = dead_ff;
      res_found_in     = res_found_ff;
      res_full_in      = res_full_ff;
      rsp_strobe_in    = 1'b0;
      rsp_max_xor_in   = rsp_max_xor_ff;
      rsp_found_in     = rsp_found_ff;
      rsp_pool_full_in = rsp_pool_full_ff;
      wr_en            = 1'b0;
      wr_addr          = new_node;
      wr_data          = '0;
      ser_ctrl         = '{load: 1'b0, shift: 1'b0, best_bit: 1'b0};

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in         = req_op;
               ser_ctrl.load = 1'b1;
               level_in      = LVL_BITS'(KEY_BITS - 1);
               node_in       = '0;
               dead_in       = 1'b0;
               if (req_op == OP_QUERY && trie_empty_ff) begin
                  res_found_in = 1'b0;
                  res_full_in  = 1'b0;
                  state_in     = ST_FINISH;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end

         ST_WALK: begin
            if (op_ff == OP_QUERY) begin
               ser_ctrl.shift = 1'b1;
               if (dead_ff) begin
                  ser_ctrl.best_bit = 1'b0;
               end else if (child_opp != '0) begin
                  ser_ctrl.best_bit = 1'b1;
                  node_in           = child_opp;
               end else if (child_same != '0) begin
                  node_in = child_same;
               end else begin
                  dead_in = 1'b1;
               end
               if (level_ff == '0) begin
                  res_found_in = 1'b1;
                  res_full_in  = 1'b0;
                  state_in     = ST_FINISH;
               end else begin
                  level_in = level_ff - LVL_BITS'(1);
               end
            end else if (child_same != '0) begin
               if (level_ff == '0) begin
                  // duplicate key
                  res_found_in  = 1'b1;
                  res_full_in   = 1'b0;
                  trie_empty_in = 1'b0;
                  state_in      = ST_FINISH;
               end else begin
                  node_in        = child_same;
                  level_in       = level_ff - LVL_BITS'(1);
                  ser_ctrl.shift = 1'b1;
               end
            end else if (pool_short) begin
               res_found_in = 1'b0;
               res_full_in  = 1'b1;
               state_in     = ST_FINISH;
            end else begin
               // hook the first new node under the last existing one
               wr_en          = 1'b1;
               wr_addr        = node_ff;
               wr_data        = key_msb ? {new_node, child0} : {child1, new_node};
               ser_ctrl.shift = 1'b1;
               state_in       = ST_ALLOC;
            end
         end

         ST_ALLOC: begin
            wr_en         = 1'b1;
            wr_addr       = new_node;
            nodes_used_in = nodes_used_ff + CNT_BITS'(1);
            if (level_ff != '0) begin
               wr_data        = key_msb ? {link_node, NODE_BITS'(0)}
                                        : {NODE_BITS'(0), link_node};
               ser_ctrl.shift = 1'b1;
               level_in       = level_ff - LVL_BITS'(1);
            end else begin
               // leaf node, no children
               wr_data       = '0;
               res_found_in  = 1'b1;
               res_full_in   = 1'b0;
               trie_empty_in = 1'b0;
               state_in      = ST_FINISH;
            end
         end

         ST_FINISH: begin
            rsp_strobe_in    = 1'b1;
            rsp_max_xor_in   = (op_ff == OP_QUERY && res_found_ff) ? best_value : '0;
            rsp_found_in     = res_found_ff;
            rsp_pool_full_in = res_full_ff;
            state_in         = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rd_addr = node_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_max_xor   = rsp_max_xor_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_pool_full = rsp_pool_full_ff;

   a_pool_bounds: assert property (@(posedge clock) disable iff (reset)
      nodes_used_ff != '0 && nodes_used_ff <= CNT_BITS'(NODE_COUNT))
      else $error("node count out of range");

   a_empty_root_only: assert property (@(posedge clock) disable iff (reset)
      (trie_empty_ff && state_ff == ST_IDLE) |-> nodes_used_ff == CNT_BITS'(1))
      else $error("empty trie holds allocated nodes");

   a_result_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> !(rsp_found_ff && rsp_pool_full_ff))
      else $error("result flags both set");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |=> !rsp_strobe_ff)
      else $error("back to back result strobes");

   a_write_in_insert: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> op_ff == OP_INSERT)
      else $error("node write outside insert");

endmodule
`default_nettype wire

### bench/tb.sv
// testbench for the binary trie max-xor engine
`timescale 1ns / 1ps
module tb;
   import bmx_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int TAIL_CYCLES = 2 * KEY_BITS_DEF + 8;

   typedef bit [11:0] node_type;

   typedef struct packed {
      bit [VALUE_BITS-1:0] max_xor;
      bit                  found;
      bit                  pool_full;
   } trie_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic                  req_op = OP_INSERT;
   logic [VALUE_BITS-1:0] req_value = '0;
   logic                  rsp_strobe;
   logic [VALUE_BITS-1:0] rsp_max_xor;
   logic                  rsp_found;
   logic                  rsp_pool_full;

   binary_trie_max_xor DUT (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_op       (req_op),
      .req_value    (req_value),
      .rsp_strobe   (rsp_strobe),
      .rsp_max_xor  (rsp_max_xor),
      .rsp_found    (rsp_found),
      .rsp_pool_full(rsp_pool_full)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // mirror of the trie: two child links per node, index 0 means no child
   node_type            trie_links [NODE_COUNT_DEF][2];
   bit [12:0]           nodes_taken = 13'd1;
   bit                  trie_is_empty = 1'b1;
   bit [VALUE_BITS-1:0] keys_held [$];

   trie_result_type     pending_results [$];
   trie_result_type     last_prediction;
   int                  fail_count = 0;
   int                  cycle_count = 0;
   int                  burst_left = 0;
   bit                  pacing_on = 1'b0;

   function automatic trie_result_type predict_trie_word(input logic op,
                                                        input bit [VALUE_BITS-1:0] value);
      trie_result_type r;
      node_type        node;
      int              needed;
      begin
         r = '0;
         node = '0;
         needed = 0;
         if (op == OP_INSERT) begin
            for (int i = VALUE_BITS - 1; i >= 0; i--) begin
               if (trie_links[node][value[i]] == '0) begin
                  needed = i + 1;
                  break;
               end
               node = trie_links[node][value[i]];
            end
            if (int'(nodes_taken) + needed > NODE_COUNT_DEF) begin
               r.pool_full = 1'b1;
            end else begin
               node = '0;
               for (int i = VALUE_BITS - 1; i >= 0; i--) begin
                  if (trie_links[node][value[i]] == '0) begin
                     trie_links[nodes_taken[11:0]][0] = '0;
                     trie_links[nodes_taken[11:0]][1] = '0;
                     trie_links[node][value[i]] = nodes_taken[11:0];
                     nodes_taken++;
                  end
                  node = trie_links[node][value[i]];
               end
               trie_is_empty = 1'b0;
               r.found = 1'b1;
               keys_held = {keys_held, value};
            end
         end else if (!trie_is_empty) begin
            r.found = 1'b1;
            for (int i = VALUE_BITS - 1; i >= 0; i--) begin
               // prefer the branch opposite to the query bit
               if (trie_links[node][!value[i]] != '0) begin
                  r.max_xor[i] = 1'b1;
                  node = trie_links[node][!value[i]];
               end else if (trie_links[node][value[i]] != '0) begin
                  node = trie_links[node][value[i]];
               end else begin
                  break;
               end
            end
         end
         return r;
      end
   endfunction

   task automatic pace_sender();
      int gap;
      begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 45) : $urandom_range(1, 4);
            start <= 1'b0;
            req_op <= 1'($urandom_range(0, 1));
            req_value <= $urandom;
            repeat (gap) @(posedge clock);
            burst_left = $urandom_range(0, 24);
         end
      end
   endtask

   task automatic issue_word(input logic op, input logic [VALUE_BITS-1:0] value);
      begin
         start <= 1'b1;
         req_op <= op;
         req_value <= value;
         @(posedge clock);
         while (busy) @(posedge clock);
         last_prediction = predict_trie_word(op, value);
         pending_results = {pending_results, last_prediction};
         if (pacing_on) pace_sender();
      end
   endtask

   task automatic drain_results();
      begin
         start <= 1'b0;
         @(posedge clock);
         while (pending_results.size() != 0) @(posedge clock);
      end
   endtask

   function automatic bit [VALUE_BITS-1:0] any_held_key();
      return keys_held[$urandom_range(0, keys_held.size() - 1)];
   endfunction

   task automatic test_empty_trie();
      begin
         issue_word(OP_QUERY, 32'h0000_0000);
         issue_word(OP_QUERY, 32'hFFFF_FFFF);
      end
   endtask

   task automatic test_directed_words();
      begin
         issue_word(OP_INSERT, 32'h0000_0000);
         issue_word(OP_QUERY,  32'h0000_0000);
         issue_word(OP_QUERY,  32'hFFFF_FFFF);
         issue_word(OP_INSERT, 32'h0000_0000);
         issue_word(OP_INSERT, 32'hFFFF_FFFF);
         issue_word(OP_QUERY,  32'h0000_0000);
         issue_word(OP_QUERY,  32'h8000_0000);
         issue_word(OP_INSERT, 32'h8000_0000);
         issue_word(OP_QUERY,  32'h7FFF_FFFF);
         issue_word(OP_QUERY,  32'hAAAA_AAAA);
         issue_word(OP_INSERT, 32'h5555_5555);
         issue_word(OP_QUERY,  32'hAAAA_AAAA);
         issue_word(OP_QUERY,  32'h5555_5555);
         issue_word(OP_INSERT, 32'h0000_0001);
         issue_word(OP_QUERY,  32'h0000_0001);
         issue_word(OP_QUERY,  32'hFFFF_FFFE);
      end
   endtask

   // keys share a few long prefixes so queries meet deep, bushy subtrees
   task automatic test_clustered_keys();
      bit [23:0] prefix [4];
      begin
         foreach (prefix[p]) prefix[p] = 24'($urandom);
         prefix[0] = 24'h000000;
         pacing_on = 1'b1;
         for (int n = 0; n < 500; n++) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: issue_word(OP_INSERT, {prefix[$urandom_range(0, 3)], 8'($urandom)});
               4:          issue_word(OP_INSERT, $urandom);
               5, 6:       issue_word(OP_QUERY, $urandom);
               7, 8:       issue_word(OP_QUERY, any_held_key() ^ (32'd1 << $urandom_range(0, 31)));
               default:    issue_word(OP_QUERY, {prefix[$urandom_range(0, 3)] ^ 24'($urandom),
                                                 8'($urandom)});
            endcase
         end
      end
   endtask

   task automatic test_pool_fill();
      int full_hits;
      int n;
      begin
         full_hits = 0;
         n = 0;
         while ((n < 300 || full_hits < 30) && n < 700) begin
            if ($urandom_range(0, 9) < 7) begin
               issue_word(OP_INSERT, $urandom);
               if (last_prediction.pool_full) full_hits++;
            end else begin
               issue_word(OP_QUERY, $urandom);
            end
            n++;
         end
      end
   endtask

   // with the pool nearly full, near-copies of stored keys often need only a few
   // nodes, so the insert lands right on the fits / does-not-fit boundary
   task automatic test_pool_boundary();
      int pos;
      begin
         for (int n = 0; n < 400; n++) begin
            case ($urandom_range(0, 19))
               0, 1, 2, 3, 4, 5, 6, 7, 8, 9: begin
                  pos = $urandom_range(0, ($urandom_range(0, 1) != 0) ? 4 : 31);
                  issue_word(OP_INSERT, any_held_key() ^ (32'd1 << pos));
               end
               10, 11, 12: issue_word(OP_INSERT, any_held_key());
               13, 14, 15: issue_word(OP_QUERY, any_held_key());
               16, 17:     issue_word(OP_QUERY, ~any_held_key());
               default:    issue_word(OP_QUERY, $urandom);
            endcase
         end
      end
   endtask

   always @(posedge clock) begin : rsp_check
      trie_result_type seen;
      trie_result_type want;
      if (!reset && rsp_strobe) begin
         seen = '{max_xor: rsp_max_xor, found: rsp_found, pool_full: rsp_pool_full};
         if (pending_results.size() == 0) begin
            if (fail_count < 10) begin
               $display("tb: unexpected word max_xor=%h found=%b pool_full=%b",
                        rsp_max_xor, rsp_found, rsp_pool_full);
            end
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (seen !== want) begin
               if (fail_count < 10) begin
                  $display("tb: mismatch max_xor exp %h got %h, found exp %b got %b, %s %b got %b",
                           want.max_xor, rsp_max_xor, want.found, rsp_found,
                           "pool_full exp", want.pool_full, rsp_pool_full);
               end
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_trie();
      test_directed_words();
      drain_results();
      test_clustered_keys();
      drain_results();
      test_pool_fill();
      drain_results();
      test_pool_boundary();
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         $display("tb: %0d words never arrived", pending_results.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

### files.f
rtl/bmx_pkg.sv
rtl/bmx_node_mem.sv
rtl/bmx_bit_serial.sv
rtl/binary_trie_max_xor.sv
bench/tb.sv
